// ----- src/md5p_pkg.sv -----
// Shared types and constants for the MD5 message padder.
`timescale 1ns / 1ps

package md5p_pkg;

    localparam int unsigned MD5P_QUEUE_DEPTH = 2;
    localparam logic [7:0]  MD5P_PAD_MARK    = 8'h80;
    localparam logic [63:0] MD5P_BYTE_BITS   = 64'd8;
    localparam logic [2:0]  MD5P_LAST_LANE   = 3'd7;
    localparam logic [2:0]  MD5P_LEN_WORD    = 3'd7;

    typedef struct packed {
        logic        has_data;
        logic [63:0] data_word;
        logic        data_blk;
        logic        has_pad;
        logic [63:0] pad_word;
        logic [2:0]  pad_idx;
        logic [63:0] len;
    } md5p_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } md5p_qstat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DATA,
        BK_PAD,
        BK_ZERO,
        BK_LEN
    } md5p_back_state_t;

endpackage

// ----- src/md5p_front.sv -----
// Front end: packs message bytes into words and queues word and padding commands.
`timescale 1ns / 1ps

module md5p_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 byte_valid,
    input  logic                 last,
    input  md5p_pkg::md5p_qstat_t qstat,
    output logic                 push,
    output md5p_pkg::md5p_cmd_t  push_cmd
);

    logic [63:0] bit_count_reg;
    logic [63:0] bit_count_next;
    logic [55:0] partial_reg;
    logic [55:0] partial_next;

    logic        accept;
    logic [2:0]  lane;
    logic [63:0] cur_word;
    logic        word_done;
    logic [63:0] cnt_after;
    logic [55:0] part_after;

    assign in_ready  = !qstat.full;
    assign accept    = in_valid && in_ready;
    assign lane      = bit_count_reg[5:3];
    assign cur_word  = {8'h00, partial_reg} | ({56'd0, data_byte} << {lane, 3'b000});
    assign word_done = byte_valid && (lane == md5p_pkg::MD5P_LAST_LANE);
    assign cnt_after = byte_valid ? bit_count_reg + md5p_pkg::MD5P_BYTE_BITS : bit_count_reg;

    always_comb
    begin
        if (word_done)
        begin
            part_after = 56'd0;
        end
        else if (byte_valid)
        begin
            part_after = cur_word[55:0];
        end
        else
        begin
            part_after = partial_reg;
        end
    end

    always_comb
    begin
        push_cmd.has_data  = word_done;
        push_cmd.data_word = cur_word;
        push_cmd.data_blk  = (bit_count_reg[8:3] == 6'd63);
        push_cmd.has_pad   = last;
        push_cmd.pad_word  = {8'h00, part_after}
                           | ({56'd0, md5p_pkg::MD5P_PAD_MARK} << {cnt_after[5:3], 3'b000});
        push_cmd.pad_idx   = cnt_after[8:6];
        push_cmd.len       = cnt_after;
    end

    assign push = accept && (word_done || last);

    always_comb
    begin
        bit_count_next = bit_count_reg;
        partial_next   = partial_reg;
        if (accept)
        begin
            if (last)
            begin
                bit_count_next = 64'd0;
                partial_next   = 56'd0;
            end
            else
            begin
                bit_count_next = cnt_after;
                partial_next   = part_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= 64'd0;
            partial_reg   <= 56'd0;
        end
        else
        begin
            bit_count_reg <= bit_count_next;
            partial_reg   <= partial_next;
        end
    end

endmodule

// ----- src/md5p_queue.sv -----
// Small command queue between the front end and the word sequencer.
`timescale 1ns / 1ps

module md5p_queue
#(
    parameter int unsigned DEPTH = md5p_pkg::MD5P_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  md5p_pkg::md5p_cmd_t   push_cmd,
    input  logic                  pop,
    output md5p_pkg::md5p_cmd_t   pop_cmd,
    output md5p_pkg::md5p_qstat_t qstat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    md5p_pkg::md5p_cmd_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign qstat.empty = (count_reg == CNT_W'(0));
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/md5p_back.sv -----
// Word sequencer: issues data words and padding words into the output register.
`timescale 1ns / 1ps

module md5p_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  md5p_pkg::md5p_qstat_t qstat,
    input  md5p_pkg::md5p_cmd_t   pop_cmd,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [63:0]           padded_word,
    output logic                  block_end,
    output logic                  message_end
);

    md5p_pkg::md5p_back_state_t state_reg;
    md5p_pkg::md5p_back_state_t state_next;
    md5p_pkg::md5p_cmd_t        cmd_reg;
    logic [2:0]                 idx_reg;
    logic [2:0]                 idx_next;

    logic        out_valid_reg;
    logic [63:0] word_reg;
    logic        blk_reg;
    logic        msg_reg;

    logic        slot_free;
    logic        load;
    logic [63:0] load_word;
    logic        load_blk;
    logic        load_msg;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = (state_reg == md5p_pkg::BK_IDLE) && !qstat.empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            md5p_pkg::BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = pop_cmd.has_data ? md5p_pkg::BK_DATA : md5p_pkg::BK_PAD;
                end
            end
            md5p_pkg::BK_DATA:
            begin
                if (slot_free)
                begin
                    state_next = cmd_reg.has_pad ? md5p_pkg::BK_PAD : md5p_pkg::BK_IDLE;
                end
            end
            md5p_pkg::BK_PAD,
            md5p_pkg::BK_ZERO:
            begin
                if (slot_free)
                begin
                    state_next = (idx_next == md5p_pkg::MD5P_LEN_WORD)
                               ? md5p_pkg::BK_LEN : md5p_pkg::BK_ZERO;
                end
            end
            md5p_pkg::BK_LEN:
            begin
                if (slot_free)
                begin
                    state_next = md5p_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = md5p_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load      = 1'b0;
        load_word = 64'd0;
        load_blk  = 1'b0;
        load_msg  = 1'b0;
        idx_next  = idx_reg + 3'd1;
        unique case (state_reg)
            md5p_pkg::BK_IDLE:
            begin
                idx_next = pop_cmd.pad_idx;
            end
            md5p_pkg::BK_DATA:
            begin
                load      = slot_free;
                load_word = cmd_reg.data_word;
                load_blk  = cmd_reg.data_blk;
                idx_next  = idx_reg;
            end
            md5p_pkg::BK_PAD:
            begin
                load      = slot_free;
                load_word = cmd_reg.pad_word;
                load_blk  = (idx_reg == md5p_pkg::MD5P_LEN_WORD);
            end
            md5p_pkg::BK_ZERO:
            begin
                load = slot_free;
            end
            md5p_pkg::BK_LEN:
            begin
                load      = slot_free;
                load_word = cmd_reg.len;
                load_blk  = 1'b1;
                load_msg  = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= pop_cmd;
        end
        if (load)
        begin
            word_reg <= load_word;
            blk_reg  <= load_blk;
            msg_reg  <= load_msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5p_pkg::BK_IDLE;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop || load)
            begin
                idx_reg <= idx_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign padded_word = word_reg;
    assign block_end   = blk_reg;
    assign message_end = msg_reg;

    a_msg_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && msg_reg |-> blk_reg)
        else $error("message end word does not close a block");

    a_len_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load && (state_reg == md5p_pkg::BK_LEN) |=> out_valid_reg && msg_reg)
        else $error("length word not presented");

    a_zero_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        load && (state_reg == md5p_pkg::BK_ZERO) |-> idx_reg != md5p_pkg::MD5P_LEN_WORD)
        else $error("zero fill word in length slot");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == md5p_pkg::BK_DATA) || (state_reg == md5p_pkg::BK_PAD))
        else $error("command taken without starting work");

endmodule

// ----- src/md5_message_padder.sv -----
// Top level of the streaming MD5 message padder.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, data_byte, byte_valid, last | sink
//  out     | out_valid, out_ready, padded_word, block_end, message_end | source
//
// Bytes are taken one beat per cycle while the command queue has room.
// The sequencer handles each completed word as a fetch and then an issue; the end of
// a message is a fetch followed by the padding words (2 to 9), one word at a time.
// Reset clears the byte count, partial word, queue and sequencer state.
// Output backpressure holds the output register, fills the queue, then drops in_ready.
`timescale 1ns / 1ps

module md5_message_padder
#(
    parameter int unsigned QUEUE_DEPTH = md5p_pkg::MD5P_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] padded_word,
    output logic        block_end,
    output logic        message_end
);

    md5p_pkg::md5p_qstat_t qstat;
    md5p_pkg::md5p_cmd_t   push_cmd;
    md5p_pkg::md5p_cmd_t   pop_cmd;
    logic                  push;
    logic                  pop;

    md5p_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .qstat      (qstat),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    md5p_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .qstat    (qstat)
    );

    md5p_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .padded_word (padded_word),
        .block_end   (block_end),
        .message_end (message_end)
    );

endmodule
